// ===== sv/cevm_pkg.sv =====
// ----------------------------------------------------------------------------
// cevm_pkg
// Shared types and constants for the curve envelope modifier.
// ----------------------------------------------------------------------------
package cevm_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Q1.16 position / Q16.16 value widths
    localparam int POS_W = 17;
    localparam int VAL_W = 32;
    localparam int ID_W  = 16;

    localparam logic [POS_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [ID_W-1:0]  FIRST_ID = 16'h0010;

    // Divider sizes: dividend magnitude and divisor
    localparam int DIVD_W    = 52;
    localparam int DIVS_W    = 18;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    // Register byte addresses
    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_MODE    = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_FLOOR   = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_CEILING = 4'h8;

    typedef enum logic [1:0] {
        CMD_EVAL = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SET  = 2'd2,
        CMD_READ = 2'd3
    } cevm_cmd_t;

    typedef enum logic [2:0] {
        MODE_CONST    = 3'd0,
        MODE_LINE_UP  = 3'd1,
        MODE_LINE_DN  = 3'd2,
        MODE_SQ_UP    = 3'd3,
        MODE_SQ_DN    = 3'd4,
        MODE_LOG_UP   = 3'd5,
        MODE_LOG_DN   = 3'd6,
        MODE_BREAKPTS = 3'd7
    } cevm_mode_t;

    typedef struct packed {
        logic        [1:0]       command;
        logic        [POS_W-1:0] position;
        logic signed [VAL_W-1:0] sample_value;
        logic signed [VAL_W-1:0] point_value;
        logic        [ID_W-1:0]  point_id;
    } cevm_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] scaled_result;
        logic        [ID_W-1:0]  assigned_id;
        logic signed [VAL_W-1:0] read_value;
        logic                    id_found;
        logic signed [VAL_W-1:0] curve_minimum;
        logic signed [VAL_W-1:0] curve_maximum;
        logic        [4:0]       point_count;
    } cevm_out_t;

    // One stored breakpoint
    typedef struct packed {
        logic        [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] val;
        logic        [ID_W-1:0]  id;
    } cevm_entry_t;

    // Broadcast control to every cell
    typedef struct packed {
        logic                    insert;
        logic        [POS_W-1:0] key;
        cevm_entry_t             new_entry;
        logic signed [VAL_W-1:0] set_val;
    } cevm_cell_ctrl_t;

endpackage

// ===== sv/cevm_cell.sv =====
// ----------------------------------------------------------------------------
// cevm_cell
// One breakpoint slot of the sorted chain; shifts up on insertion.
// ----------------------------------------------------------------------------
module cevm_cell (
    input  logic                  clk,
    input  cevm_pkg::cevm_cell_ctrl_t ctrl,
    input  logic                  in_use,
    input  logic                  at_end,
    input  logic                  set_en,
    input  cevm_pkg::cevm_entry_t prev_entry,
    input  logic                  prev_gt,
    output cevm_pkg::cevm_entry_t entry,
    output logic                  gt
);
    import cevm_pkg::*;

    cevm_entry_t entry_reg;

    // slot holds a point above the new key
    assign gt    = in_use && (ctrl.key < entry_reg.pos);
    assign entry = entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.insert && (in_use || at_end))
        begin
            if (prev_gt)
                entry_reg <= prev_entry;
            else if (gt || at_end)
                entry_reg <= ctrl.new_entry;
        end
        else if (set_en)
        begin
            entry_reg.val <= ctrl.set_val;
        end
    end

endmodule

// ===== sv/cevm_divider.sv =====
// ----------------------------------------------------------------------------
// cevm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cevm_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [cevm_pkg::DIVD_W-1:0]     dividend,
    input  logic [cevm_pkg::DIVS_W-1:0]     divisor,
    output logic                            done,
    output logic [cevm_pkg::DIVD_W-1:0]     quotient
);
    import cevm_pkg::*;

    logic [DIVS_W:0]      rem_reg;
    logic [DIVD_W-1:0]    quo_reg;
    logic [DIVS_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVS_W:0] shifted;
    logic            fits;

    // trial subtract
    assign shifted = {rem_reg[DIVS_W-1:0], quo_reg[DIVD_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/curve_envelope_modifier_core.sv =====
// ----------------------------------------------------------------------------
// curve_envelope_modifier_core
// Curve evaluation and sample scaling with a sorted breakpoint chain.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  item     | in        | item_valid/stall     | cevm_in_t
//  result   | out       | result_valid/stall   | cevm_out_t
//  apb      | in/out    | psel/penable/pready  | 32-bit registers
//
// One item at a time: idle takes it, adds pass the insert state, then a
// scan of the stored points, one per cycle. Set, read and add then finish;
// evaluate passes scale and saturate in const mode or on a zero-width span,
// after factor, multiply and add in line modes, after square and those three
// in square and log modes, and after a multiply and the 52-step divider for
// interpolation. The finish cycle repeats while a result waits stalled in the
// output register. Reset empties the table and sets the next id to 16.
module curve_envelope_modifier_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  cevm_pkg::cevm_in_t        item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output cevm_pkg::cevm_out_t       result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [cevm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import cevm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INSERT, S_SCAN, S_SQUARE, S_FACTOR, S_APPLY_MUL, S_APPLY_ADD,
        S_BP_MUL, S_DIV_START, S_DIV_WAIT, S_SCALE, S_SAT, S_FINISH
    } state_t;

    state_t state_reg;

    // configuration
    logic [2:0]              mode_reg;
    logic signed [VAL_W-1:0] floor_reg;
    logic signed [VAL_W-1:0] ceil_reg;

    // item
    logic [1:0]              cmd_reg;
    logic [POS_W-1:0]        k_reg;
    logic signed [VAL_W-1:0] sample_reg;
    logic signed [VAL_W-1:0] pval_reg;
    logic [ID_W-1:0]         pid_reg;

    // table state
    logic [CNT_W-1:0]        count_reg;
    logic [ID_W-1:0]         next_id_reg;

    // scan
    logic [CNT_W-1:0]        scan_idx_reg;
    logic signed [18:0]      lp_reg;
    logic signed [18:0]      rp_reg;
    logic signed [VAL_W-1:0] lv_reg;
    logic signed [VAL_W-1:0] rv_reg;
    logic                    rfound_reg;
    logic signed [VAL_W-1:0] lo_reg;
    logic signed [VAL_W-1:0] hi_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic signed [VAL_W-1:0] readv_reg;
    logic [ID_W-1:0]         assigned_reg;

    // arithmetic
    logic [POS_W-1:0]        sq_reg;
    logic [POS_W-1:0]        fact_reg;
    logic signed [50:0]      prod_reg;
    logic signed [VAL_W-1:0] curve_reg;
    logic [DIVD_W-1:0]       mag_reg;
    logic                    neg_reg;
    logic [DIVS_W-1:0]       dvs_reg;
    logic signed [63:0]      sprod_reg;
    logic signed [VAL_W-1:0] scaled_reg;

    logic      out_valid_reg;
    cevm_out_t out_reg;

    // ---------------- configuration port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr)
            ADDR_MODE:    prdata = {29'd0, mode_reg};
            ADDR_FLOOR:   prdata = floor_reg;
            ADDR_CEILING: prdata = ceil_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------- breakpoint chain ----------------
    cevm_cell_ctrl_t cell_ctrl;
    cevm_entry_t     cell_entry [MAX_POINTS];
    logic            cell_gt    [MAX_POINTS];
    logic            scan_end;

    assign scan_end = (scan_idx_reg == count_reg);

    assign cell_ctrl.insert        = (state_reg == S_INSERT) &&
                                     (count_reg < CNT_W'(MAX_POINTS));
    assign cell_ctrl.key           = k_reg;
    assign cell_ctrl.new_entry.pos = k_reg;
    assign cell_ctrl.new_entry.val = pval_reg;
    assign cell_ctrl.new_entry.id  = next_id_reg;
    assign cell_ctrl.set_val       = pval_reg;

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        cevm_entry_t prev_e;
        logic        prev_g;
        if (i == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_rest
            assign prev_e = cell_entry[i-1];
            assign prev_g = cell_gt[i-1];
        end

        cevm_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .in_use     (CNT_W'(i) < count_reg),
            .at_end     (CNT_W'(i) == count_reg),
            .set_en     ((state_reg == S_SCAN) && scan_end && found_reg &&
                         (cmd_reg == CMD_SET) && (hit_idx_reg == IDX_W'(i))),
            .prev_entry (prev_e),
            .prev_gt    (prev_g),
            .entry      (cell_entry[i]),
            .gt         (cell_gt[i])
        );
    end

    // ---------------- scan step ----------------
    cevm_entry_t             cur;
    logic                    id_hit;
    logic signed [VAL_W-1:0] eff_val;

    assign cur     = cell_entry[scan_idx_reg[IDX_W-1:0]];
    assign id_hit  = ((cmd_reg == CMD_SET) || (cmd_reg == CMD_READ)) &&
                     !found_reg && (cur.id == pid_reg);
    assign eff_val = (id_hit && (cmd_reg == CMD_SET)) ? pval_reg : cur.val;

    // ---------------- arithmetic helpers ----------------
    logic [POS_W-1:0]        sq_base;
    logic [33:0]             sq_full;
    logic signed [32:0]      span;
    logic signed [18:0]      dk;
    logic signed [32:0]      dv;
    logic signed [51:0]      bp_prod;
    logic [31:0]             q_low;
    logic signed [47:0]      shifted_p;
    logic signed [VAL_W-1:0] sat_val;
    logic [DIVD_W-1:0]       div_q;
    logic                    div_done;
    logic                    div_start;

    assign sq_base   = ((mode_reg == MODE_SQ_UP) || (mode_reg == MODE_LOG_DN)) ?
                       k_reg : (ONE_Q16 - k_reg);
    assign sq_full   = sq_base * sq_base;
    assign span      = {ceil_reg[31], ceil_reg} - {floor_reg[31], floor_reg};
    assign dk        = $signed({2'b00, k_reg}) - lp_reg;
    assign dv        = {rv_reg[31], rv_reg} - {lv_reg[31], lv_reg};
    assign bp_prod   = dk * dv;
    assign q_low     = neg_reg ? (32'd0 - div_q[31:0]) : div_q[31:0];
    assign shifted_p = sprod_reg[63:16];
    assign div_start = (state_reg == S_DIV_START);

    // saturate the scaled product to 32 bits
    always_comb
    begin
        if ((sprod_reg[63:47] != {17{1'b0}}) && (sprod_reg[63:47] != {17{1'b1}}))
            sat_val = sprod_reg[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            sat_val = shifted_p[31:0];
    end

    cevm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- main sequencer ----------------
    logic [ID_W-1:0] id_inc;
    logic            fin_fire;
    assign id_inc   = next_id_reg + 1'b1;
    assign fin_fire = (state_reg == S_FINISH) && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_CONST;
            floor_reg     <= '0;
            ceil_reg      <= 32'sh00010000;
            count_reg     <= '0;
            next_id_reg   <= FIRST_ID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_wr)
            begin
                case (paddr)
                    ADDR_MODE:    mode_reg  <= pwdata[2:0];
                    ADDR_FLOOR:   floor_reg <= pwdata;
                    ADDR_CEILING: ceil_reg  <= pwdata;
                    default:      ;
                endcase
            end

            // output register valid
            if (fin_fire)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !result_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        cmd_reg      <= item.command;
                        k_reg        <= (item.position > ONE_Q16) ? ONE_Q16 : item.position;
                        sample_reg   <= item.sample_value;
                        pval_reg     <= item.point_value;
                        pid_reg      <= item.point_id;
                        scan_idx_reg <= '0;
                        lp_reg       <= -19'sd1;
                        rp_reg       <= 19'sd65537;
                        lv_reg       <= ceil_reg;
                        rv_reg       <= ceil_reg;
                        rfound_reg   <= 1'b0;
                        lo_reg       <= ceil_reg;
                        hi_reg       <= ceil_reg;
                        found_reg    <= 1'b0;
                        hit_idx_reg  <= '0;
                        readv_reg    <= '0;
                        assigned_reg <= '0;
                        scaled_reg   <= '0;
                        state_reg    <= (item.command == CMD_ADD) ? S_INSERT : S_SCAN;
                    end
                end

                S_INSERT:
                begin
                    if (count_reg < CNT_W'(MAX_POINTS))
                    begin
                        count_reg    <= count_reg + 1'b1;
                        assigned_reg <= next_id_reg;
                        next_id_reg  <= (id_inc == '0) ? FIRST_ID : id_inc;
                    end
                    state_reg <= S_SCAN;
                end

                S_SCAN:
                begin
                    if (!scan_end)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        if (id_hit)
                        begin
                            found_reg   <= 1'b1;
                            hit_idx_reg <= scan_idx_reg[IDX_W-1:0];
                            if (cmd_reg == CMD_READ)
                                readv_reg <= cur.val;
                        end
                        if (eff_val < lo_reg)
                            lo_reg <= eff_val;
                        if (eff_val > hi_reg)
                            hi_reg <= eff_val;
                        if (k_reg >= cur.pos)
                        begin
                            lp_reg <= $signed({2'b00, cur.pos});
                            lv_reg <= cur.val;
                        end
                        if (!rfound_reg && (k_reg <= cur.pos))
                        begin
                            rp_reg     <= $signed({2'b00, cur.pos});
                            rv_reg     <= cur.val;
                            rfound_reg <= 1'b1;
                        end
                    end
                    else if (cmd_reg != CMD_EVAL)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_CONST:
                            begin
                                curve_reg <= ceil_reg;
                                state_reg <= S_SCALE;
                            end
                            MODE_LINE_UP, MODE_LINE_DN:
                                state_reg <= S_FACTOR;
                            MODE_BREAKPTS:
                            begin
                                if (rp_reg == lp_reg)
                                begin
                                    curve_reg <= lv_reg;
                                    state_reg <= S_SCALE;
                                end
                                else
                                    state_reg <= S_BP_MUL;
                            end
                            default:
                                state_reg <= S_SQUARE;
                        endcase
                    end
                end

                S_SQUARE:
                begin
                    sq_reg    <= sq_full[32:16];
                    state_reg <= S_FACTOR;
                end

                S_FACTOR:
                begin
                    case (mode_reg)
                        MODE_LINE_UP:             fact_reg <= k_reg;
                        MODE_LINE_DN:             fact_reg <= ONE_Q16 - k_reg;
                        MODE_SQ_UP, MODE_SQ_DN:   fact_reg <= sq_reg;
                        default:                  fact_reg <= ONE_Q16 - sq_reg;
                    endcase
                    state_reg <= S_APPLY_MUL;
                end

                S_APPLY_MUL:
                begin
                    prod_reg  <= span * $signed({1'b0, fact_reg});
                    state_reg <= S_APPLY_ADD;
                end

                S_APPLY_ADD:
                begin
                    // floor division by 65536 is an arithmetic shift
                    curve_reg <= floor_reg + $signed(prod_reg[47:16]);
                    state_reg <= S_SCALE;
                end

                S_BP_MUL:
                begin
                    neg_reg   <= bp_prod[51];
                    mag_reg   <= bp_prod[51] ? DIVD_W'(-bp_prod) : DIVD_W'(bp_prod);
                    dvs_reg   <= DIVS_W'(rp_reg - lp_reg);
                    state_reg <= S_DIV_START;
                end

                S_DIV_START:
                    state_reg <= S_DIV_WAIT;

                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        curve_reg <= lv_reg + $signed(q_low);
                        state_reg <= S_SCALE;
                    end
                end

                S_SCALE:
                begin
                    sprod_reg <= sample_reg * curve_reg;
                    state_reg <= S_SAT;
                end

                S_SAT:
                begin
                    scaled_reg <= sat_val;
                    state_reg  <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (fin_fire)
                    begin
                        out_reg.scaled_result <= scaled_reg;
                        out_reg.assigned_id   <= assigned_reg;
                        out_reg.read_value    <= readv_reg;
                        out_reg.id_found      <= found_reg;
                        out_reg.point_count   <= count_reg;
                        case (mode_reg)
                            MODE_BREAKPTS:
                            begin
                                out_reg.curve_minimum <= lo_reg;
                                out_reg.curve_maximum <= hi_reg;
                            end
                            MODE_CONST:
                            begin
                                out_reg.curve_minimum <= ceil_reg;
                                out_reg.curve_maximum <= ceil_reg;
                            end
                            default:
                            begin
                                out_reg.curve_minimum <= floor_reg;
                                out_reg.curve_maximum <= ceil_reg;
                            end
                        endcase
                        state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== sv/cevm_checker.sv =====
// ----------------------------------------------------------------------------
// cevm_sva
// Port-level checks for the curve envelope modifier.
// ----------------------------------------------------------------------------
module cevm_sva (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_stall,
    input cevm_pkg::cevm_out_t result
);
    import cevm_pkg::*;

    // stalled result transfer holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // table never exceeds its depth
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.point_count <= 5'(MAX_POINTS))
        else $error("point count above table depth");

    // an id lookup never also reports a new id
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.id_found |-> result.assigned_id == '0)
        else $error("id found together with assigned id");

    // an add reports no scaled or read value
    a_add: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.assigned_id != '0) |->
            (result.scaled_result == '0) && (result.read_value == '0))
        else $error("add result carries other fields");

endmodule

bind curve_envelope_modifier_core cevm_sva u_cevm_sva (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
